[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the deduplicating table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHDT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chdt assertion failed");

// Next-cycle implication, checked outside reset.
`define CHDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chdt assertion failed");

`endif

[hw/rtl/chdt_pkg.sv]
// Package with sizes, codes, state encoding and the CRC32C byte step.
`timescale 1ns / 1ps
`default_nettype none
package chdt_pkg;

   localparam int MAX_ENTRIES   = 1024;
   localparam int ENTRY_W       = $clog2(MAX_ENTRIES);
   localparam int CAP_W         = 11;
   localparam int MAX_KEY_BYTES = 64;
   localparam int KEY_WORDS     = (MAX_KEY_BYTES + 7) / 8;
   localparam int WORD_W        = $clog2(KEY_WORDS);
   localparam int LEN_W         = 7;
   localparam int NWORDS_W      = WORD_W + 1;
   localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4,
      ST_TOO_LONG  = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_BYTE, S_DIV, S_HEAD_RD, S_HEAD_CHK, S_ENT_RD,
      S_ENT_CHK, S_KEY_CHK, S_DECIDE, S_COPY, S_LINK, S_TAIL, S_RESULT
   } state_type;

   // One reflected CRC32C step over a single byte.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/crc32c_hash_dedup_table.sv]
// Top level of the CRC32C hashed, chained deduplicating key table.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
//
//  Channel   Direction  Handshake            Payload
//  req_      in         req_valid/req_stall  req_type, req_key_chunk, req_chunk_bytes,
//                                            req_last_chunk
//  rsp_      out        rsp_valid/rsp_stall  rsp_status, rsp_entry_index
//  csr_      in         csr_we               csr_wdata (table capacity)
//
//  A chunk is hashed one byte per cycle through the CRC32C unit; a final chunk
//  with a key that is too long goes straight to its result. Any other final chunk
//  then passes through the bit-serial remainder unit and the bucket head read, and
//  per chain entry through a read of its length and link and a check of each key
//  word; each step waits on the registered read of the entry memories.
//  An insert copies the key words, writes the entry length and link, then chains it.
//  After reset a clearing pass over the 1024 bucket heads empties them; no
//  transaction is accepted during it, while capacity writes are taken as ever.
//  A finished result waits in the output register; only the next result stalls.
//
module crc32c_hash_dedup_table
   import chdt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [CAP_W-1:0]    csr_wdata,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic                req_type,
   input  wire logic [63:0]         req_key_chunk,
   input  wire logic [3:0]          req_chunk_bytes,
   input  wire logic                req_last_chunk,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [2:0]          rsp_status,
   output      logic [ENTRY_W-1:0]  rsp_entry_index
);

   state_type state_ff, state_in;

   // Control and datapath registers.
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [CAP_W-1:0]   capeff_ff, capeff_in;
   logic [ENTRY_W-1:0] clr_ff, clr_in;
   logic [CAP_W-1:0]   count_ff, count_in;
   logic [63:0]        chunk_ff, chunk_in;
   logic [3:0]         nb_ff, nb_in;
   logic [3:0]         bidx_ff, bidx_in;
   logic               last_ff, last_in;
   logic               type_ff, type_in;
   logic [63:0]        pend_ff [KEY_WORDS];
   logic [63:0]        pend_in [KEY_WORDS];
   logic [LEN_W-1:0]   plen_ff, plen_in;
   logic [31:0]        crc_ff, crc_in;
   logic               long_ff, long_in;
   logic [31:0]        div_ff, div_in;
   logic [CAP_W-1:0]   rem_ff, rem_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [ENTRY_W-1:0] cur_ff, cur_in;
   logic [ENTRY_W-1:0] tail_ff, tail_in;
   logic               have_tail_ff, have_tail_in;
   logic [ENTRY_W:0]   nsave_ff, nsave_in;
   logic [WORD_W-1:0]  w_ff, w_in;
   logic [2:0]         res_status_ff, res_status_in;
   logic [ENTRY_W-1:0] res_index_ff, res_index_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [ENTRY_W-1:0] rsp_index_ff, rsp_index_in;

   // Memories: bucket heads, entry lengths, chain links and key words.
   logic [ENTRY_W:0]   head_mem [MAX_ENTRIES];
   logic [LEN_W-1:0]   len_mem  [MAX_ENTRIES];
   logic [ENTRY_W:0]   next_mem [MAX_ENTRIES];
   logic [63:0]        key_mem  [MAX_ENTRIES * KEY_WORDS];

   logic [ENTRY_W-1:0]        head_addr, len_addr, next_addr;
   logic [ENTRY_W+WORD_W-1:0] key_addr;
   logic                      head_we, len_we, next_we, key_we;
   logic [ENTRY_W:0]          head_wdata, next_wdata;
   logic [ENTRY_W:0]          head_q, next_q;
   logic [LEN_W-1:0]          len_q;
   logic [63:0]               key_q;

   // Shared conditions.
   logic [ENTRY_W-1:0]  new_entry;
   logic [NWORDS_W-1:0] nwords;
   logic                bytes_done;
   logic                out_free;
   logic                len_match;
   logic                key_word_eq;
   logic                key_last_word;
   logic [7:0]          cur_byte;
   logic [CAP_W-1:0]    div_trial;

   assign new_entry     = count_ff[ENTRY_W-1:0];
   assign nwords        = NWORDS_W'((8'(plen_ff) + 8'd7) >> 3);
   assign bytes_done    = (bidx_ff >= nb_ff);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign len_match     = (len_q == plen_ff);
   assign key_word_eq   = (key_q == pend_ff[w_ff]);
   assign key_last_word = ({1'b0, w_ff} + NWORDS_W'(1)) == nwords;
   assign cur_byte      = chunk_ff[{bidx_ff[2:0], 3'b000} +: 8];
   assign div_trial     = {rem_ff[CAP_W-2:0], div_ff[31]};

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_addr] <= head_wdata;
      end
      head_q <= head_mem[head_addr];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_addr] <= plen_ff;
      end
      len_q <= len_mem[len_addr];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_addr] <= next_wdata;
      end
      next_q <= next_mem[next_addr];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_addr] <= pend_ff[w_ff];
      end
      key_q <= key_mem[key_addr];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == {ENTRY_W{1'b1}}) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_BYTE;
         end
         S_BYTE: begin
            if (bytes_done) begin
               if (!last_ff) state_in = S_IDLE;
               else if (long_ff) state_in = S_RESULT;
               else state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (cnt_ff == 5'd31) state_in = S_HEAD_RD;
         end
         S_HEAD_RD: state_in = S_HEAD_CHK;
         S_HEAD_CHK: begin
            state_in = head_q[ENTRY_W] ? S_ENT_RD : S_DECIDE;
         end
         S_ENT_RD: state_in = S_ENT_CHK;
         S_ENT_CHK: begin
            if (len_match) begin
               state_in = (nwords == '0) ? S_RESULT : S_KEY_CHK;
            end else begin
               state_in = next_q[ENTRY_W] ? S_ENT_RD : S_DECIDE;
            end
         end
         S_KEY_CHK: begin
            if (!key_word_eq) state_in = nsave_ff[ENTRY_W] ? S_ENT_RD : S_DECIDE;
            else if (key_last_word) state_in = S_RESULT;
         end
         S_DECIDE: begin
            if (type_ff || count_ff >= capeff_ff) state_in = S_RESULT;
            else state_in = (nwords == '0) ? S_LINK : S_COPY;
         end
         S_COPY: begin
            if (key_last_word) state_in = S_LINK;
         end
         S_LINK:   state_in = S_TAIL;
         S_TAIL:   state_in = S_RESULT;
         S_RESULT: begin
            if (out_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // Memory strobes and the input handshake.
   always_comb begin
      req_stall  = (state_ff != S_IDLE);
      head_addr  = rem_ff[ENTRY_W-1:0];
      head_we    = 1'b0;
      head_wdata = {1'b1, new_entry};
      len_addr   = cur_ff;
      len_we     = 1'b0;
      next_addr  = cur_ff;
      next_we    = 1'b0;
      next_wdata = {1'b1, new_entry};
      key_addr   = {new_entry, w_ff};
      key_we     = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            head_addr  = clr_ff;
            head_we    = 1'b1;
            head_wdata = '0;
         end
         S_ENT_CHK: key_addr = {cur_ff, {WORD_W{1'b0}}};
         S_KEY_CHK: key_addr = {cur_ff, w_ff + WORD_W'(1)};
         S_COPY:    key_we   = 1'b1;
         S_LINK: begin
            len_addr   = new_entry;
            len_we     = 1'b1;
            next_addr  = new_entry;
            next_we    = 1'b1;
            next_wdata = '0;
         end
         S_TAIL: begin
            next_addr = tail_ff;
            next_we   = have_tail_ff;
            head_we   = !have_tail_ff;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      cap_in        = csr_we ? csr_wdata : cap_ff;
      capeff_in     = capeff_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      chunk_in      = chunk_ff;
      nb_in         = nb_ff;
      bidx_in       = bidx_ff;
      last_in       = last_ff;
      type_in       = type_ff;
      pend_in       = pend_ff;
      plen_in       = plen_ff;
      crc_in        = crc_ff;
      long_in       = long_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      cur_in        = cur_ff;
      tail_in       = tail_ff;
      have_tail_in  = have_tail_ff;
      nsave_in      = nsave_ff;
      w_in          = w_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      case (state_ff)
         S_CLEAR: clr_in = clr_ff + ENTRY_W'(1);
         S_IDLE: begin
            chunk_in = req_key_chunk;
            nb_in    = (req_chunk_bytes > 4'd8) ? 4'd8 : req_chunk_bytes;
            last_in  = req_last_chunk;
            type_in  = req_type;
            bidx_in  = '0;
         end
         S_BYTE: begin
            if (!bytes_done) begin
               bidx_in = bidx_ff + 4'd1;
               if (!long_ff) begin
                  if (plen_ff >= LEN_W'(MAX_KEY_BYTES)) begin
                     long_in = 1'b1;
                  end else begin
                     // A byte that opens a word also clears its stale upper bytes.
                     if (plen_ff[2:0] == 3'd0) begin
                        pend_in[plen_ff[5:3]] = {56'd0, cur_byte};
                     end else begin
                        pend_in[plen_ff[5:3]] = pend_ff[plen_ff[5:3]] |
                           ({56'd0, cur_byte} << {plen_ff[2:0], 3'b000});
                     end
                     plen_in = plen_ff + LEN_W'(1);
                     crc_in  = crc_byte(crc_ff, cur_byte);
                  end
               end
            end else if (last_ff) begin
               div_in        = ~crc_ff;
               rem_in        = '0;
               cnt_in        = '0;
               res_status_in = ST_TOO_LONG;
               res_index_in  = '0;
               if (cap_ff == '0) capeff_in = CAP_W'(1);
               else if (cap_ff > CAP_W'(MAX_ENTRIES)) capeff_in = CAP_W'(MAX_ENTRIES);
               else capeff_in = cap_ff;
            end
         end
         S_DIV: begin
            div_in = {div_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            rem_in = (div_trial >= capeff_ff) ? (div_trial - capeff_ff) : div_trial;
         end
         S_HEAD_CHK: begin
            cur_in       = head_q[ENTRY_W-1:0];
            have_tail_in = 1'b0;
         end
         S_ENT_CHK: begin
            nsave_in = next_q;
            w_in     = '0;
            if (len_match) begin
               res_status_in = type_ff ? ST_FOUND : ST_DUPLICATE;
               res_index_in  = cur_ff;
            end else begin
               tail_in      = cur_ff;
               have_tail_in = 1'b1;
               cur_in       = next_q[ENTRY_W-1:0];
            end
         end
         S_KEY_CHK: begin
            w_in = w_ff + WORD_W'(1);
            if (!key_word_eq) begin
               tail_in      = cur_ff;
               have_tail_in = 1'b1;
               cur_in       = nsave_ff[ENTRY_W-1:0];
            end
         end
         S_DECIDE: begin
            w_in         = '0;
            res_index_in = '0;
            if (type_ff) res_status_in = ST_NOT_FOUND;
            else if (count_ff >= capeff_ff) res_status_in = ST_FULL;
         end
         S_COPY: w_in = w_ff + WORD_W'(1);
         S_TAIL: begin
            count_in      = count_ff + CAP_W'(1);
            res_status_in = ST_INSERTED;
            res_index_in  = new_entry;
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               plen_in       = '0;
               crc_in        = '1;
               long_in       = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cap_ff       <= CAP_W'(MAX_ENTRIES);
         clr_ff       <= '0;
         count_ff     <= '0;
         plen_ff      <= '0;
         crc_ff       <= '1;
         long_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         plen_ff      <= plen_in;
         crc_ff       <= crc_in;
         long_ff      <= long_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      capeff_ff     <= capeff_in;
      chunk_ff      <= chunk_in;
      nb_ff         <= nb_in;
      bidx_ff       <= bidx_in;
      last_ff       <= last_in;
      type_ff       <= type_in;
      pend_ff       <= pend_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      cur_ff        <= cur_in;
      tail_ff       <= tail_in;
      have_tail_ff  <= have_tail_in;
      nsave_ff      <= nsave_in;
      w_ff          <= w_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_index_ff;

   // The entry count never passes the table size.
   `CHDT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CAP_W'(MAX_ENTRIES))
   // The running remainder stays below the modulus throughout the division.
   `CHDT_ASSERT_NOW(a_rem_bound, clock, reset, state_ff == S_DIV, rem_ff < capeff_ff)
   // A new result appears only out of the result state.
   `CHDT_ASSERT_NOW(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_RESULT)
   // Linking an entry bumps the count by exactly one.
   `CHDT_ASSERT_NEXT(a_count_step, clock, reset, state_ff == S_TAIL, count_ff == $past(count_ff) + CAP_W'(1))

endmodule
`default_nettype wire
